### src/msta_pkg.sv
// Shared types and constants for the multi-stream timestamp aligner.
// No dependencies; imported by every module of the block.
`default_nettype none

package msta_pkg;

  localparam int NUM_SOURCES_DEF = 8;
  localparam int SOURCE_W        = 3;
  localparam int STAMP_W         = 64;
  localparam int MASK_W          = 8;
  localparam int CNT_W           = 32;
  localparam int ADV_W           = 33;

  typedef enum logic [1:0] {
    FUNC_EVENT = 2'd0,
    FUNC_END   = 2'd1,
    FUNC_RDERR = 2'd2,
    FUNC_SHUT  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_WAIT   = 3'd0,
    ST_GROUP  = 3'd1,
    ST_END    = 3'd2,
    ST_RDERR  = 3'd3,
    ST_NOCONV = 3'd4,
    ST_SHUT   = 3'd5,
    ST_STOP   = 3'd6
  } status_t;

  typedef struct packed {
    logic [SOURCE_W-1:0] source;
    func_t               func;
    logic [STAMP_W-1:0]  timestamp;
  } in_word_t;

  typedef struct packed {
    status_t             status;
    logic [STAMP_W-1:0]  group_timestamp;
    logic [MASK_W-1:0]   need_mask;
    logic [CNT_W-1:0]    regressions;
    logic [CNT_W-1:0]    mismatches;
    logic [CNT_W-1:0]    events_skipped;
    logic [CNT_W-1:0]    groups_formed;
    logic [CNT_W-1:0]    incomplete_groups;
  } out_word_t;

  typedef struct packed {
    logic regression;
    logic mismatch;
    logic skipped;
    logic group;
    logic incomplete;
  } bump_t;

  typedef struct packed {
    logic [CNT_W-1:0] regressions;
    logic [CNT_W-1:0] mismatches;
    logic [CNT_W-1:0] events_skipped;
    logic [CNT_W-1:0] groups_formed;
    logic [CNT_W-1:0] incomplete_groups;
  } stats_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v, input logic en);
    sat_inc = (en && !(&v)) ? v + CNT_W'(1) : v;
  endfunction

endpackage

`default_nettype wire

### src/msta_counters.sv
// Saturating statistics counters of the aligner.
// Depends on msta_pkg (bump_t, stats_t, sat_inc).
`default_nettype none

module msta_counters (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            fire,
  input  wire msta_pkg::bump_t bump,
  output msta_pkg::stats_t     stats_next
);
  import msta_pkg::*;

  stats_t stats;

  always_comb begin
    stats_next.regressions       = sat_inc(stats.regressions, bump.regression);
    stats_next.mismatches        = sat_inc(stats.mismatches, bump.mismatch);
    stats_next.events_skipped    = sat_inc(stats.events_skipped, bump.skipped);
    stats_next.groups_formed     = sat_inc(stats.groups_formed, bump.group);
    stats_next.incomplete_groups = sat_inc(stats.incomplete_groups, bump.incomplete);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stats <= '0;
    end else if (fire) begin
      stats <= stats_next;
    end
  end

endmodule

`default_nettype wire

### src/msta_core.sv
// Head store, catch-up tracking and group decision of the aligner.
// Depends on msta_pkg (in_word_t, status_t, bump_t, widths).
`default_nettype none

module msta_core #(
  parameter int NUM_SOURCES = msta_pkg::NUM_SOURCES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wen,
  input  wire logic [msta_pkg::CNT_W-1:0]  cfg_wdata,
  input  wire logic                        fire,
  input  wire msta_pkg::in_word_t          word,
  output msta_pkg::status_t                status,
  output logic [msta_pkg::STAMP_W-1:0]     group_timestamp,
  output logic [msta_pkg::MASK_W-1:0]      need_mask,
  output msta_pkg::bump_t                  bump
);
  import msta_pkg::*;

  localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int WIDE  = (NUM_SOURCES > MASK_W) ? NUM_SOURCES : MASK_W;

  logic [CNT_W-1:0]       max_advances;
  logic [STAMP_W-1:0]     head_stamp [NUM_SOURCES];
  logic [STAMP_W-1:0]     prior_stamp [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] head_valid, head_valid_next;
  logic [NUM_SOURCES-1:0] prior_valid, prior_valid_next;
  logic [NUM_SOURCES-1:0] catching_up, catching_up_next;
  logic [STAMP_W-1:0]     target_stamp, target_stamp_next;
  logic [STAMP_W-1:0]     run_max, run_max_next;
  logic [ADV_W-1:0]       advance_count, advance_count_next;
  logic                   halted, halted_next;

  logic [IDX_W-1:0]       src_idx;
  logic [NUM_SOURCES-1:0] sel;
  logic [NUM_SOURCES-1:0] need_cur;
  logic [NUM_SOURCES-1:0] need_new;
  logic [NUM_SOURCES-1:0] diff;
  logic [NUM_SOURCES-1:0] need_res;
  logic [WIDE-1:0]        need_wide;
  logic                   src_ok;
  logic                   catching;
  logic                   write_head;
  logic [STAMP_W-1:0]     ts;

  always_comb begin
    ts       = word.timestamp;
    src_idx  = IDX_W'(word.source);
    src_ok   = 32'(word.source) < 32'(NUM_SOURCES);
    sel      = '0;
    if (src_ok) begin
      sel[src_idx] = 1'b1;
    end
    need_cur = (|catching_up) ? catching_up : ~head_valid;
    catching = |catching_up;
    run_max_next = (head_valid == '0) ? ts : ((ts > run_max) ? ts : run_max);
    for (int i = 0; i < NUM_SOURCES; i++) begin
      diff[i] = ((sel[i] ? ts : head_stamp[i]) != run_max_next);
    end
  end

  always_comb begin
    head_valid_next    = head_valid;
    prior_valid_next   = prior_valid;
    catching_up_next   = catching_up;
    target_stamp_next  = target_stamp;
    advance_count_next = advance_count;
    halted_next        = halted;
    write_head         = 1'b0;
    need_new           = '0;
    status             = ST_WAIT;
    group_timestamp    = '0;
    need_res           = '0;
    bump               = '0;
    if (halted) begin
      status = ST_STOP;
    end else if (word.func == FUNC_SHUT) begin
      halted_next = 1'b1;
      status      = ST_SHUT;
    end else if (!(|(need_cur & sel))) begin
      need_res = need_cur;
    end else begin
      bump.skipped = catching;
      unique case (word.func)
        FUNC_END: begin
          bump.incomplete = catching || (head_valid != '0);
          halted_next     = 1'b1;
          status          = ST_END;
        end
        FUNC_RDERR: begin
          halted_next = 1'b1;
          status      = ST_RDERR;
        end
        FUNC_EVENT: begin
          write_head       = 1'b1;
          bump.regression  = (|(prior_valid & sel)) && (ts < prior_stamp[src_idx]);
          prior_valid_next = prior_valid | sel;
          head_valid_next  = head_valid | sel;
          if (!(&advance_count)) begin
            advance_count_next = advance_count + ADV_W'(1);
          end
          if (catching && (max_advances != '0)
              && (advance_count_next > ADV_W'(max_advances))) begin
            halted_next = 1'b1;
            status      = ST_NOCONV;
          end else begin
            if (catching && (ts >= target_stamp)) begin
              catching_up_next = catching_up & ~sel;
            end
            need_new = (|catching_up_next) ? catching_up_next : ~head_valid_next;
            if (need_new != '0) begin
              need_res = need_new;
            end else if (diff == '0) begin
              bump.group         = 1'b1;
              head_valid_next    = '0;
              advance_count_next = '0;
              status             = ST_GROUP;
              group_timestamp    = run_max_next;
              need_res           = '1;
            end else begin
              bump.mismatch     = 1'b1;
              target_stamp_next = run_max_next;
              catching_up_next  = diff;
              need_res          = diff;
            end
          end
        end
        default: begin
          halted_next = 1'b1;
          status      = ST_SHUT;
        end
      endcase
    end
    need_wide = WIDE'(need_res);
    need_mask = need_wide[MASK_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_advances <= '0;
    end else if (cfg_wen) begin
      max_advances <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid    <= '0;
      prior_valid   <= '0;
      catching_up   <= '0;
      target_stamp  <= '0;
      run_max       <= '0;
      advance_count <= '0;
      halted        <= 1'b0;
    end else if (fire) begin
      head_valid    <= head_valid_next;
      prior_valid   <= prior_valid_next;
      catching_up   <= catching_up_next;
      target_stamp  <= target_stamp_next;
      advance_count <= advance_count_next;
      halted        <= halted_next;
      if (write_head) begin
        run_max <= run_max_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && write_head) begin
      for (int i = 0; i < NUM_SOURCES; i++) begin
        if (sel[i]) begin
          head_stamp[i]  <= ts;
          prior_stamp[i] <= ts;
        end
      end
    end
  end

endmodule

`default_nettype wire

### src/multi_stream_timestamp_aligner_top.sv
// Top level of the multi-stream timestamp aligner: core, counters, result register.
// Depends on msta_pkg, msta_core and msta_counters.
//
//   channel   | signals                    | direction
//   ----------+----------------------------+----------
//   input     | in_valid, in_stall, in_word | in
//   result    | out_valid, out_stall, out_word | out
//   config    | cfg_wen, cfg_wdata         | in
//
// One word in gives one word out, registered in the cycle after it is taken.
// A new word is taken every cycle while in_stall is low; the head compare runs in the same cycle as the write.
// Result register holds while out_stall is high; in_stall follows a full stalled register.
// Synchronous reset clears valid bits, counters, limit and the halt flag.
`default_nettype none

module multi_stream_timestamp_aligner_top #(
  parameter int NUM_SOURCES = msta_pkg::NUM_SOURCES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wen,
  input  wire logic [msta_pkg::CNT_W-1:0]  cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire msta_pkg::in_word_t          in_word,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output msta_pkg::out_word_t              out_word
);
  import msta_pkg::*;

  logic                 fire;
  status_t              status;
  logic [STAMP_W-1:0]   group_timestamp;
  logic [MASK_W-1:0]    need_mask;
  bump_t                bump;
  stats_t               stats_next;

  assign in_stall = out_valid && out_stall;
  assign fire     = in_valid && !in_stall;

  msta_core #(
    .NUM_SOURCES(NUM_SOURCES)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .cfg_wen         (cfg_wen),
    .cfg_wdata       (cfg_wdata),
    .fire            (fire),
    .word            (in_word),
    .status          (status),
    .group_timestamp (group_timestamp),
    .need_mask       (need_mask),
    .bump            (bump)
  );

  msta_counters u_counters (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .bump       (bump),
    .stats_next (stats_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word.status            <= status;
      out_word.group_timestamp   <= group_timestamp;
      out_word.need_mask         <= need_mask;
      out_word.regressions       <= stats_next.regressions;
      out_word.mismatches        <= stats_next.mismatches;
      out_word.events_skipped    <= stats_next.events_skipped;
      out_word.groups_formed     <= stats_next.groups_formed;
      out_word.incomplete_groups <= stats_next.incomplete_groups;
    end
  end

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("accepted word produced no result");

  a_stamp_only_on_group: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_word.status != ST_GROUP)) |-> (out_word.group_timestamp == '0))
    else $error("group timestamp set without a group");

  a_no_need_when_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ((out_word.status == ST_END) || (out_word.status == ST_RDERR)
      || (out_word.status == ST_NOCONV) || (out_word.status == ST_SHUT)
      || (out_word.status == ST_STOP))) |-> (out_word.need_mask == '0))
    else $error("need mask set with a terminal status");

  a_stop_stays: assert property (@(posedge clk) disable iff (rst)
    (fire && out_valid && !out_stall && (out_word.status == ST_STOP)) |=>
      (out_word.status == ST_STOP))
    else $error("block left the stopped state without reset");

endmodule

`default_nettype wire
